// ----- sv/bb3rgb_pkg.sv -----
`timescale 1ns / 1ps

package bb3rgb_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned PixW        = 3 * ChanW;
  localparam int unsigned RowW        = 12;
  localparam int unsigned ColOutW     = 10;
  localparam int unsigned FrameWidthW = 11;
  localparam int unsigned CfgW        = 12;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned SumW        = 12;
  localparam int unsigned NumW        = 13;
  localparam int unsigned CountW      = 4;
  localparam int unsigned RecipW      = 20;
  localparam int unsigned RecipShift  = 20;
  localparam int unsigned ProdW       = NumW + RecipW;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned OutDataW    = 48;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

  localparam logic [FrameWidthW-1:0] WidthReset  = 11'd1024;
  localparam logic [RowW-1:0]        HeightReset = 12'd768;

  typedef logic [PixW-1:0] pix_t;

  // px[k][v]: column k (0 = c-2, 1 = c-1, 2 = c), row v (0 = r-2, 1 = r-1, 2 = r)
  typedef struct packed {
    pix_t [2:0][2:0]    px;
    logic [2:0]         cm;
    logic [2:0]         rm_up;
    logic [2:0]         rm_lo;
    logic [RowW-1:0]    row;
    logic [ColOutW-1:0] col;
    logic [3:0]         en;
  } job_t;

  // ceil(2^RecipShift / (2*n)) for n = 1..9
  function automatic logic [RecipW-1:0] recip(input logic [CountW-1:0] n);
    logic [RecipW-1:0] m;
    case (n)
      4'd1:    m = 20'd524288;
      4'd2:    m = 20'd262144;
      4'd3:    m = 20'd174763;
      4'd4:    m = 20'd131072;
      4'd5:    m = 20'd104858;
      4'd6:    m = 20'd87382;
      4'd7:    m = 20'd74899;
      4'd8:    m = 20'd65536;
      4'd9:    m = 20'd58255;
      default: m = 20'd524288;
    endcase
    return m;
  endfunction

endpackage

// ----- sv/bb3rgb_ram.sv -----
`timescale 1ns / 1ps

module bb3rgb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bb3rgb_front.sv -----
`timescale 1ns / 1ps

module bb3rgb_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bb3rgb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bb3rgb_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                                s_valid_i,
  output logic                                s_ready_o,
  input  bb3rgb_pkg::pix_t                    s_pix_i,
  output logic                                push_o,
  output bb3rgb_pkg::job_t                    job_o,
  input  logic                                full_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_READ = 2'b10
  } fstate_e;

  fstate_e state_q, state_d;

  logic [bb3rgb_pkg::FrameWidthW-1:0] width_q;
  logic [bb3rgb_pkg::RowW-1:0]        height_q;
  logic [CW-1:0]                      col_q;
  logic [bb3rgb_pkg::RowW-1:0]        row_q;
  bb3rgb_pkg::pix_t                   win_q [6];

  bb3rgb_pkg::pix_t                   pix_q;
  logic [CW-1:0]                      c_q;
  logic [bb3rgb_pkg::RowW-1:0]        r_q;

  logic [CW-1:0]                      w_last, c_eff;
  logic [bb3rgb_pkg::RowW-1:0]        h_last, r_eff;
  logic                               accept, go, has_out;
  logic                               c_ge1, c_ge2, c_end, r_ge1, r_ge2, r_end;
  bb3rgb_pkg::pix_t                   older_rd, newer_rd;

  always_comb begin
    if (width_q == '0) begin
      w_last = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(width_q - 11'd1);
    end
    h_last = (height_q == '0) ? '0 : height_q - 12'd1;
    c_eff  = (col_q > w_last) ? w_last : col_q;
    r_eff  = (row_q > h_last) ? h_last : row_q;
  end

  assign s_ready_o = (state_q == F_IDLE);
  assign accept    = s_valid_i && s_ready_o;

  assign c_ge1 = (c_q != '0);
  assign c_ge2 = (c_q > CW'(1));
  assign c_end = (c_q == w_last);
  assign r_ge1 = (r_q != '0);
  assign r_ge2 = (r_q > 12'd1);
  assign r_end = (r_q == h_last);

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      job_o.px[0][v] = win_q[v];
      job_o.px[1][v] = win_q[3 + v];
    end
    job_o.px[2][0] = older_rd;
    job_o.px[2][1] = newer_rd;
    job_o.px[2][2] = pix_q;
    job_o.cm       = {1'b1, c_ge1, c_ge2};
    job_o.rm_up    = {1'b1, 1'b1, r_ge2};
    job_o.rm_lo    = {1'b1, r_ge1, 1'b0};
    job_o.row      = r_q;
    job_o.col      = bb3rgb_pkg::ColOutW'(c_q);
    job_o.en       = {r_end & c_end, r_end & c_ge1, r_ge1 & c_end, r_ge1 & c_ge1};
  end

  assign has_out = (job_o.en != 4'd0);
  assign go      = (state_q == F_READ) && (!has_out || !full_i);
  assign push_o  = go && has_out;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_READ;
        end
      end
      F_READ: begin
        if (go) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  bb3rgb_ram #(
    .WIDTH(bb3rgb_pkg::PixW),
    .DEPTH(MAX_WIDTH)
  ) u_older (
    .clk_i  (clk_i),
    .we_i   (go),
    .waddr_i(c_q),
    .wdata_i(newer_rd),
    .re_i   (accept),
    .raddr_i(c_eff),
    .rdata_o(older_rd)
  );

  bb3rgb_ram #(
    .WIDTH(bb3rgb_pkg::PixW),
    .DEPTH(MAX_WIDTH)
  ) u_newer (
    .clk_i  (clk_i),
    .we_i   (go),
    .waddr_i(c_q),
    .wdata_i(pix_q),
    .re_i   (accept),
    .raddr_i(c_eff),
    .rdata_o(newer_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      width_q  <= bb3rgb_pkg::WidthReset;
      height_q <= bb3rgb_pkg::HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bb3rgb_pkg::RegFrameWidth: begin
            width_q <= cfg_wdata_i[bb3rgb_pkg::FrameWidthW-1:0];
          end
          bb3rgb_pkg::RegFrameHeight: begin
            height_q <= cfg_wdata_i;
          end
          default: ;
        endcase
      end
      if (go) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k] <= win_q[3 + k];
        end
        win_q[3] <= older_rd;
        win_q[4] <= newer_rd;
        win_q[5] <= pix_q;
        if (c_end) begin
          col_q <= '0;
          row_q <= r_end ? '0 : r_q + 12'd1;
        end else begin
          col_q <= c_q + CW'(1);
          row_q <= r_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= s_pix_i;
      c_q   <= c_eff;
      r_q   <= r_eff;
    end
  end

`ifndef SYNTHESIS
  a_push_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (state_q == F_READ) && !full_i)
    else $error("front pushed a job into a full queue");
`endif

endmodule

// ----- sv/bb3rgb_fifo.sv -----
`timescale 1ns / 1ps

module bb3rgb_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bb3rgb_pkg::job_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output bb3rgb_pkg::job_t rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(bb3rgb_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(bb3rgb_pkg::QueueDepth + 1);

  bb3rgb_pkg::job_t mem_q [bb3rgb_pkg::QueueDepth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(bb3rgb_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(bb3rgb_pkg::QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(bb3rgb_pkg::QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(bb3rgb_pkg::QueueDepth))
    else $error("job queue count out of range");
`endif

endmodule

// ----- sv/bb3rgb_back.sv -----
`timescale 1ns / 1ps

module bb3rgb_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bb3rgb_pkg::job_t                  job_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [bb3rgb_pkg::OutDataW-1:0]   m_data_o,
  output logic                              m_last_o
);

  localparam int unsigned ChanW = bb3rgb_pkg::ChanW;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SUM  = 3'b010,
    B_MUL  = 3'b100
  } bstate_e;

  bstate_e state_q, state_d;

  bb3rgb_pkg::job_t                     job_q;
  logic [3:0]                           en_q;
  logic [bb3rgb_pkg::NumW-1:0]          xr_q, xg_q, xb_q;
  logic [bb3rgb_pkg::RecipW-1:0]        rc_q;
  logic [bb3rgb_pkg::RowW-1:0]          orow_q;
  logic [bb3rgb_pkg::ColOutW-1:0]       ocol_q;
  logic                                 olast_q;

  logic                                 m_valid_q;
  logic [ChanW-1:0]                     mr_q, mg_q, mb_q;
  logic [bb3rgb_pkg::RowW-1:0]          mrow_q;
  logic [bb3rgb_pkg::ColOutW-1:0]       mcol_q;
  logic                                 mlast_q;

  logic [1:0]                           sel;
  logic [3:0]                           sel_bit;
  logic [2:0]                           cmask, rmask;
  logic [bb3rgb_pkg::SumW-1:0]          sr, sg, sb;
  logic [bb3rgb_pkg::CountW-1:0]        cnt;
  logic [bb3rgb_pkg::ProdW-1:0]         pr, pg, pb;
  logic                                 out_free, load;

  always_comb begin
    if (en_q[0]) begin
      sel = 2'd0;
    end else if (en_q[1]) begin
      sel = 2'd1;
    end else if (en_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    sel_bit = 4'd1 << sel;
    cmask   = sel[0] ? (job_q.cm & 3'b110) : job_q.cm;
    rmask   = sel[1] ? job_q.rm_lo : job_q.rm_up;
  end

  always_comb begin
    sr  = '0;
    sg  = '0;
    sb  = '0;
    cnt = '0;
    for (int k = 0; k < 3; k++) begin
      for (int v = 0; v < 3; v++) begin
        if (cmask[k] && rmask[v]) begin
          sr  = sr + bb3rgb_pkg::SumW'(job_q.px[k][v][ChanW-1:0]);
          sg  = sg + bb3rgb_pkg::SumW'(job_q.px[k][v][2*ChanW-1:ChanW]);
          sb  = sb + bb3rgb_pkg::SumW'(job_q.px[k][v][3*ChanW-1:2*ChanW]);
          cnt = cnt + 4'd1;
        end
      end
    end
  end

  assign pr = bb3rgb_pkg::ProdW'(xr_q) * bb3rgb_pkg::ProdW'(rc_q);
  assign pg = bb3rgb_pkg::ProdW'(xg_q) * bb3rgb_pkg::ProdW'(rc_q);
  assign pb = bb3rgb_pkg::ProdW'(xb_q) * bb3rgb_pkg::ProdW'(rc_q);

  assign out_free = !m_valid_q || m_ready_i;
  assign load     = (state_q == B_MUL) && out_free;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          state_d = B_SUM;
        end
      end
      B_SUM: state_d = B_MUL;
      B_MUL: begin
        if (out_free) begin
          state_d = (en_q != 4'd0) ? B_SUM : B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      en_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        en_q <= job_i.en;
      end else if (state_q == B_SUM) begin
        en_q <= en_q & ~sel_bit;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == B_SUM) begin
      xr_q    <= {sr, 1'b0} + bb3rgb_pkg::NumW'(cnt);
      xg_q    <= {sg, 1'b0} + bb3rgb_pkg::NumW'(cnt);
      xb_q    <= {sb, 1'b0} + bb3rgb_pkg::NumW'(cnt);
      rc_q    <= bb3rgb_pkg::recip(cnt);
      orow_q  <= sel[1] ? job_q.row : job_q.row - 12'd1;
      ocol_q  <= sel[0] ? job_q.col : job_q.col - 10'd1;
      olast_q <= ((en_q & ~sel_bit) == 4'd0);
    end
    if (load) begin
      mr_q    <= pr[bb3rgb_pkg::RecipShift +: ChanW];
      mg_q    <= pg[bb3rgb_pkg::RecipShift +: ChanW];
      mb_q    <= pb[bb3rgb_pkg::RecipShift +: ChanW];
      mrow_q  <= orow_q;
      mcol_q  <= ocol_q;
      mlast_q <= olast_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_last_o  = mlast_q;
  assign m_data_o  = {2'b00, mcol_q, mrow_q, mb_q, mg_q, mr_q};

`ifndef SYNTHESIS
  a_sum_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SUM) |-> (en_q != 4'd0))
    else $error("back end summing with no pending result");
`endif

endmodule

// ----- sv/box_blur_3x3_rgb_core.sv -----
`timescale 1ns / 1ps

// Channel  Handshake                    Payload
// cfg      cfg_we_i                     cfg_idx_i, cfg_wdata_i
// s_axis   s_axis_tvalid/s_axis_tready  s_axis_tdata: red, green, blue
// m_axis   m_axis_tvalid/m_axis_tready  m_axis_tdata: red, green, blue, row, col; m_axis_tlast
//
// Front end reads the line stores on taking a pixel, then writes back; it takes the next pixel only
// after that write-back, which waits for queue room if it pushes a job. Back end pops a job, then per
// result sums the window and does the reciprocal multiply: one result, or up to four at the last pixel.
// Reset clears counters and window and loads 1024 x 768; line stores are not cleared.
// A 2-job queue and one output register let each side stall on its own.

module box_blur_3x3_rgb_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bb3rgb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bb3rgb_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bb3rgb_pkg::PixW-1:0]         s_axis_tdata,  // red_in, green_in, blue_in
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // red_out, green_out, blue_out, out_row, out_col, 2 zero bits
  output logic [bb3rgb_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast
);

  logic             push, full, pop, empty;
  bb3rgb_pkg::job_t job_in, job_out;

  bb3rgb_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_pix_i    (s_axis_tdata),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  bb3rgb_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(job_in),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(job_out),
    .empty_o(empty)
  );

  bb3rgb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (job_out),
    .empty_i  (empty),
    .pop_o    (pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata),
    .m_last_o (m_axis_tlast)
  );

endmodule

// ----- tb/box_blur_3x3_rgb_core_test.sv -----
`timescale 1ns / 1ps

module box_blur_3x3_rgb_core_test;

  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned RandomItems  = 236;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } blur_px_t;

  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                cfg_we_i      = 1'b0;
  logic [bb3rgb_pkg::CfgIdxW-1:0]      cfg_idx_i     = '0;
  logic [bb3rgb_pkg::CfgW-1:0]         cfg_wdata_i   = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [bb3rgb_pkg::PixW-1:0]         s_axis_tdata  = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [bb3rgb_pkg::OutDataW-1:0]     m_axis_tdata;
  logic                                m_axis_tlast;

  // frame geometry and blur state as the block should hold it
  logic [10:0] cfg_width  = 11'd1024;
  logic [11:0] cfg_height = 12'd768;
  logic [23:0] upper_line [MaxWidth];
  logic [23:0] prev_line  [MaxWidth];
  logic [23:0] win_px     [6];
  logic [23:0] nbhd       [3][3];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  blur_px_t    blur_expect_q [$];
  int unsigned errors      = 0;
  int unsigned item_count  = 0;
  int unsigned burst_left  = 0;
  bit          steady      = 1'b0;
  bit          hold_pending = 1'b0;

  box_blur_3x3_rgb_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < MaxWidth; i++) begin
      upper_line[i] = '0;
      prev_line[i]  = '0;
    end
    for (int i = 0; i < 6; i++) win_px[i] = '0;
  end

  function automatic void push_blur(input logic [2:0] cm, input logic [2:0] rm,
                                    input int unsigned orow, input int unsigned ocol);
    int unsigned sr, sg, sb, n;
    blur_px_t px;
    sr = 0;
    sg = 0;
    sb = 0;
    n  = 0;
    for (int k = 0; k < 3; k++) begin
      for (int v = 0; v < 3; v++) begin
        if (cm[k] && rm[v]) begin
          sr += nbhd[k][v][23:16];
          sg += nbhd[k][v][15:8];
          sb += nbhd[k][v][7:0];
          n++;
        end
      end
    end
    px.red   = 8'((2 * sr + n) / (2 * n));
    px.green = 8'((2 * sg + n) / (2 * n));
    px.blue  = 8'((2 * sb + n) / (2 * n));
    px.row   = 12'(orow);
    px.col   = 10'(ocol);
    px.last  = 1'b0;
    blur_expect_q.push_back(px);
  endfunction

  function automatic void predict_pixel(input logic [7:0] red, input logic [7:0] green,
                                        input logic [7:0] blue);
    int unsigned w, h, c, r, first;
    logic [2:0] cm, rm;
    blur_px_t tail;
    w = (cfg_width == 0) ? 1 : cfg_width;
    if (w > MaxWidth) w = MaxWidth;
    h = (cfg_height == 0) ? 1 : cfg_height;
    c = (col_pos < w - 1) ? col_pos : w - 1;
    r = (row_pos < h - 1) ? row_pos : h - 1;
    for (int k = 0; k < 2; k++) begin
      for (int v = 0; v < 3; v++) nbhd[k][v] = win_px[k * 3 + v];
    end
    nbhd[2][0] = upper_line[c];
    nbhd[2][1] = prev_line[c];
    nbhd[2][2] = {red, green, blue};
    cm = {1'b1, c >= 1, c >= 2};
    first = blur_expect_q.size();
    if (r >= 1) begin
      rm = {1'b1, 1'b1, r >= 2};
      if (c >= 1) push_blur(cm, rm, r - 1, c - 1);
      if (c == w - 1) push_blur(cm & 3'b110, rm, r - 1, c);
    end
    if (r == h - 1) begin
      rm = {1'b1, r >= 1, 1'b0};
      if (c >= 1) push_blur(cm, rm, r, c - 1);
      if (c == w - 1) push_blur(cm & 3'b110, rm, r, c);
    end
    if (blur_expect_q.size() > first) begin
      tail = blur_expect_q.pop_back();
      tail.last = 1'b1;
      blur_expect_q.push_back(tail);
    end
    for (int v = 0; v < 3; v++) begin
      win_px[v]     = win_px[3 + v];
      win_px[3 + v] = nbhd[2][v];
    end
    upper_line[c] = nbhd[2][1];
    prev_line[c]  = nbhd[2][2];
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  task automatic check_word();
    blur_px_t got, want;
    got.red   = m_axis_tdata[7:0];
    got.green = m_axis_tdata[15:8];
    got.blue  = m_axis_tdata[23:16];
    got.row   = m_axis_tdata[35:24];
    got.col   = m_axis_tdata[45:36];
    got.last  = m_axis_tlast;
    if (blur_expect_q.size() == 0) begin
      report_mismatch("unexpected word at row", 32'(got.row), 0);
    end else begin
      want = blur_expect_q.pop_front();
      if (got.red != want.red) report_mismatch("red", 32'(got.red), 32'(want.red));
      if (got.green != want.green) begin
        report_mismatch("green", 32'(got.green), 32'(want.green));
      end
      if (got.blue != want.blue) report_mismatch("blue", 32'(got.blue), 32'(want.blue));
      if (got.row != want.row) report_mismatch("row", 32'(got.row), 32'(want.row));
      if (got.col != want.col) report_mismatch("col", 32'(got.col), 32'(want.col));
      if (got.last != want.last) report_mismatch("tlast", 32'(got.last), 32'(want.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_word();
  end

  initial begin : rx_side
    int unsigned hold_left, seg_left, mode, period, phase;
    logic rdy;
    hold_left = 0;
    seg_left  = 0;
    mode      = 0;
    period    = 2;
    phase     = 0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
          period   = $urandom_range(2, 5);
        end
        seg_left--;
        phase++;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (phase % period) == 0;
          default: rdy = $urandom_range(0, 9) != 0;
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("[box_blur_3x3_rgb_core] ERROR");
    $finish;
  end

  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (steady) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(red, green, blue);
    item_count++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (blur_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bb3rgb_pkg::CfgIdxW-1:0] idx,
                           input logic [bb3rgb_pkg::CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bb3rgb_pkg::RegFrameWidth) cfg_width = val[10:0];
    else cfg_height = val;
    @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [bb3rgb_pkg::CfgW-1:0] wval,
                           input logic [bb3rgb_pkg::CfgW-1:0] hval);
    wait_idle();
    write_reg(bb3rgb_pkg::RegFrameWidth, wval);
    write_reg(bb3rgb_pkg::RegFrameHeight, hval);
  endtask

  function automatic logic [7:0] pick_chan(input int unsigned mode);
    case (mode)
      0:       return 8'($urandom_range(0, 255));
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(250, 255));
    endcase
  endfunction

  task automatic send_random(input int unsigned count, input int unsigned mode);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(pick_chan(mode), pick_chan(mode), pick_chan(mode));
    end
  endtask

  task automatic test_corner_frames();
    set_frame(12'd1, 12'd1);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    set_frame(12'd0, 12'd0);
    send_pixel(8'h00, 8'h00, 8'h00);
    set_frame(12'd1, 12'd3);
    send_pixel(8'h00, 8'hFF, 8'h80);
    send_pixel(8'hFF, 8'h00, 8'h7F);
    send_pixel(8'h01, 8'hFE, 8'h00);
    set_frame(12'd3, 12'd1);
    send_pixel(8'hAA, 8'h55, 8'hFF);
    send_pixel(8'h55, 8'hAA, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'h80);
    set_frame(12'd2, 12'd2);
    send_random(4, 0);
    set_frame(12'd3, 12'd3);
    for (int i = 0; i < 9; i++) begin
      send_pixel((i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF, (i % 2) ? 8'hFF : 8'h00);
    end
  endtask

  task automatic test_mid_frame_resize();
    set_frame(12'd8, 12'd4);
    send_random(5, 0);
    wait_idle();
    write_reg(bb3rgb_pkg::RegFrameWidth, 12'd3);
    send_random(10, 0);
    set_frame(12'd1, 12'd4095);
    send_random(5, 0);
    wait_idle();
    write_reg(bb3rgb_pkg::RegFrameHeight, 12'd3);
    send_random(1, 0);
  endtask

  task automatic test_backpressure();
    set_frame(12'd6, 12'd5);
    steady       = 1'b1;
    hold_pending = 1'b1;
    send_random(30, 0);
    steady = 1'b0;
  endtask

  task automatic test_full_width();
    set_frame(12'hFFF, 12'd1);
    send_random(40, 0);
    wait_idle();
    write_reg(bb3rgb_pkg::RegFrameWidth, 12'd41);
    send_random(1, 0);
    set_frame(12'd1025, 12'd1);
    send_random(20, 1);
    wait_idle();
    write_reg(bb3rgb_pkg::RegFrameWidth, 12'd21);
    send_random(1, 1);
  endtask

  task automatic test_random_frames();
    int unsigned w, h, stop_at, left;
    stop_at = item_count + RandomItems;
    while (item_count < stop_at) begin
      case ($urandom_range(0, 7))
        0:       w = $urandom_range(0, 3);
        1:       w = $urandom_range(17, 64);
        default: w = $urandom_range(4, 16);
      endcase
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      left = stop_at - item_count;
      while (h > 1 && ((w == 0) ? 1 : w) * h > left) h--;
      set_frame({1'($urandom_range(0, 1)), 11'(w)}, 12'(h));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      send_random(w * h, $urandom_range(0, 3));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_frames();
    test_mid_frame_resize();
    test_backpressure();
    test_full_width();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("[box_blur_3x3_rgb_core] OK");
    end else begin
      $display("[box_blur_3x3_rgb_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bb3rgb_pkg.sv
sv/bb3rgb_ram.sv
sv/bb3rgb_front.sv
sv/bb3rgb_fifo.sv
sv/bb3rgb_back.sv
sv/box_blur_3x3_rgb_core.sv
tb/box_blur_3x3_rgb_core_test.sv
